[src/psort_pkg.sv]
// shared types and constants for the priority insertion sorter
package psort_pkg;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;

   // one stored entry: signed sort key and its opaque handle
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [HANDLE_W-1:0]     handle;
   } entry_type;

   // compare request to the shared compare unit
   typedef struct packed {
      logic signed [KEY_W-1:0] cur_key;
      logic signed [KEY_W-1:0] prev_key;
      logic                    descending;
   } cmp_req_type;

endpackage

[src/priority_insertion_sorter_unit.sv]
// priority insertion sorter top level: insertion sequencer, store and output register
//
//   channel   direction  handshake               word
//   req_*     in         req_valid / req_ready   key, handle, last flag
//   rsp_*     out        rsp_valid / rsp_ready   sorted key, handle, end flag, drop flag
//   csr_*     in         csr_valid / csr_ready   sort direction (always ready)
//
// an insertion into a non-empty store compares the new word against each stored entry it
// passes, shifting each such entry one place toward the tail; an empty or full store needs no walk;
// the single store read port and the one shared comparator walk the list one position a cycle
// a last word then emits the list one result at a time while rsp_ready is high
// reset (synchronous, active high) empties the store and clears the drop flag;
// store contents need no clearing since only positions below the count are read
// req_ready is low during insertion and emission; rsp stalls simply hold the word
module priority_insertion_sorter_unit #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [psort_pkg::KEY_W-1:0] req_priority_req,
   input  logic [psort_pkg::HANDLE_W-1:0]    req_payload,
   input  logic                              req_last_entry,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [psort_pkg::KEY_W-1:0] rsp_sorted_priority,
   output logic [psort_pkg::HANDLE_W-1:0]    rsp_sorted_payload,
   output logic                              rsp_end_of_list,
   output logic                              rsp_overflowed,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_descending
);
   import psort_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,       // compare new word against stored neighbor, shift on move
      ST_PLACE,     // new word reached the head
      ST_EMIT_RD,   // first read of the emission pass
      ST_EMIT_LOAD, // read data into the output register
      ST_EMIT_WAIT  // hold output until taken
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               drop_ff, drop_in;
   logic               desc_ff, desc_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               last_ff, last_in;
   entry_type          new_ff, new_in;
   logic               rsp_valid_ff, rsp_valid_in;
   entry_type          out_ff, out_in;
   logic               end_ff, end_in;
   logic               ovf_ff, ovf_in;

   // store ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;

   // shared compare unit
   cmp_req_type        cmp_req;
   logic               move;

   logic               req_fire;
   logic               rsp_fire;
   logic               full;
   logic [CNT_W-1:0]   count_dec;
   logic [CNT_W-1:0]   idx_inc;

   psort_mem #(
      .DEPTH (MAX_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psort_cmp u_cmp (
      .cmp_req (cmp_req),
      .move    (move)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid_ff & rsp_ready;
   assign csr_ready = 1'b1;
   assign full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign count_dec = count_ff - CNT_W'(1);
   assign idx_inc   = CNT_W'(idx_ff) + CNT_W'(1);

   // new word is the current entry, stored neighbor is the previous one
   assign cmp_req.cur_key    = new_ff.key;
   assign cmp_req.prev_key   = rd_data.key;
   assign cmp_req.descending = desc_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      desc_in      = desc_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      end_in       = end_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = new_ff;
      rd_addr      = idx_ff;

      if (csr_valid) begin
         desc_in = csr_descending;
      end

      case (state_ff)
         ST_IDLE: begin
            // read the current tail as the first neighbor
            rd_addr = count_dec[IDX_W-1:0];
            if (req_fire) begin
               new_in.key    = req_priority_req;
               new_in.handle = req_payload;
               last_in       = req_last_entry;
               idx_in        = '0;
               if (full) begin
                  // store full: drop the word, still emit on last
                  drop_in = 1'b1;
                  if (req_last_entry) begin
                     state_in = ST_EMIT_RD;
                  end
               end else if (count_ff == '0) begin
                  // empty store: word goes straight to the head
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_data.key    = req_priority_req;
                  wr_data.handle = req_payload;
                  count_in     = CNT_W'(1);
                  if (req_last_entry) begin
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  pos_in   = count_ff[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
                  state_in = ST_CMP;
               end
            end
         end

         ST_CMP: begin
            // prefetch the neighbor one further toward the head
            rd_addr = pos_ff - IDX_W'(2);
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (move) begin
               // neighbor shifts one place toward the tail
               wr_data = rd_data;
               pos_in  = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_data = new_ff;
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = new_ff;
            state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
         end

         ST_EMIT_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_EMIT_LOAD;
         end

         ST_EMIT_LOAD: begin
            out_in       = rd_data;
            end_in       = (idx_inc == count_ff);
            ovf_in       = drop_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_WAIT;
         end

         ST_EMIT_WAIT: begin
            rd_addr = idx_inc[IDX_W-1:0];
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (end_ff) begin
                  // list done: store empties
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_inc[IDX_W-1:0];
                  state_in = ST_EMIT_LOAD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload and walk registers need no reset
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      new_ff  <= new_in;
      out_ff  <= out_in;
      end_ff  <= end_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_priority = out_ff.key;
   assign rsp_sorted_payload  = out_ff.handle;
   assign rsp_end_of_list     = end_ff;
   assign rsp_overflowed      = ovf_ff;

endmodule

[src/psort_cmp.sv]
// shared key compare unit: decides whether the new entry moves past its neighbor
module psort_cmp (
   input  psort_pkg::cmp_req_type cmp_req,
   output logic                   move
);
   import psort_pkg::*;

   // later entries pass equal keys in both modes
   always_comb begin
      if (cmp_req.descending) begin
         move = (cmp_req.cur_key >= cmp_req.prev_key);
      end else begin
         move = (cmp_req.prev_key >= cmp_req.cur_key);
      end
   end

endmodule

[src/psort_mem.sv]
// entry store: one write port, one registered read port
module psort_mem #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  psort_pkg::entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output psort_pkg::entry_type       rd_data
);
   import psort_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/priority_insertion_sorter_unit_test.sv]
// testbench for the priority insertion sorter: random sets checked against a local sort model
`timescale 1ns / 100ps

module priority_insertion_sorter_unit_test;

   import psort_pkg::*;

   localparam int MAX_ENTRIES  = 64;
   localparam int CLOCK_PERIOD = 8;
   // watchdog limit for the whole run, sized for heavy stalls on both sides
   localparam int RUN_LIMIT    = 400000;
   // one full insertion pass plus margin, so the block is idle before a csr write
   localparam int SETTLE       = MAX_ENTRIES + 8;
   localparam int RANDOM_ITEMS = 200;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   // sort direction register values
   typedef enum bit {
      ORDER_ASCENDING  = 1'b0,
      ORDER_DESCENDING = 1'b1
   } sort_order_type;

   // key flavors for random sets
   typedef enum int {
      KEYS_FULL_RANGE = 0,
      KEYS_FEW_VALUES = 1,
      KEYS_EXTREMES   = 2
   } key_flavor_type;

   // one input word as the sender offers it
   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [HANDLE_W-1:0]     handle;
      logic                    last;
   } req_word_type;

   // one output word as the block should deliver it
   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic [HANDLE_W-1:0]     handle;
      logic                    end_flag;
      logic                    drop_flag;
   } sorted_word_type;

   logic clock;
   logic reset;

   logic                    req_valid;
   logic                    req_ready;
   logic signed [KEY_W-1:0] req_priority_req;
   logic [HANDLE_W-1:0]     req_payload;
   logic                    req_last_entry;

   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [KEY_W-1:0] rsp_sorted_priority;
   logic [HANDLE_W-1:0]     rsp_sorted_payload;
   logic                    rsp_end_of_list;
   logic                    rsp_overflowed;

   logic csr_valid;
   logic csr_ready;
   logic csr_descending;

   // words waiting to be offered, and sorted words due from the block
   req_word_type    req_words_waiting[$];
   sorted_word_type due_words[$];

   // local copy of the sorter state
   entry_type      sort_store[MAX_ENTRIES];
   int             stored_count;
   bit             entries_dropped;
   sort_order_type sort_order;

   // idle odds in percent for each side
   int send_idle_pct;
   int recv_idle_pct;

   int mismatch_count;
   int cycle_count;

   priority_insertion_sorter_unit #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_priority_req(req_priority_req),
      .req_payload(req_payload),
      .req_last_entry(req_last_entry),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sorted_priority(rsp_sorted_priority),
      .rsp_sorted_payload(rsp_sorted_payload),
      .rsp_end_of_list(rsp_end_of_list),
      .rsp_overflowed(rsp_overflowed),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_descending(csr_descending)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // one line per mismatch, counted for the final verdict
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      mismatch_count++;
   endtask

   // insert one accepted word into the local store; a last word flushes the list
   task automatic sort_in(input logic signed [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle,
                          input logic last);
      int pos;
      entry_type swap;
      sorted_word_type out_word;
      if (stored_count >= MAX_ENTRIES) begin
         // store full: word is lost, flag sticks until the list goes out
         entries_dropped = 1'b1;
      end else begin
         pos = stored_count;
         sort_store[pos].key = key;
         sort_store[pos].handle = handle;
         stored_count++;
         // walk toward the head; equal keys never stop the new word
         while (pos > 0 &&
                ((sort_order == ORDER_DESCENDING) ?
                 (sort_store[pos].key >= sort_store[pos-1].key) :
                 (sort_store[pos-1].key >= sort_store[pos].key))) begin
            swap = sort_store[pos];
            sort_store[pos] = sort_store[pos-1];
            sort_store[pos-1] = swap;
            pos--;
         end
      end
      if (last) begin
         for (int k = 0; k < stored_count; k++) begin
            out_word.key = sort_store[k].key;
            out_word.handle = sort_store[k].handle;
            out_word.end_flag = (k == stored_count - 1);
            out_word.drop_flag = entries_dropped;
            due_words.push_back(out_word);
         end
         stored_count = 0;
         entries_dropped = 1'b0;
      end
   endtask

   // sender: holds valid and payload until accepted, then maybe idles
   always @(posedge clock) begin : drive_req
      req_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            sort_in(req_priority_req, req_payload, req_last_entry);
         if (!req_valid || req_ready) begin
            if (req_words_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = req_words_waiting.pop_front();
               req_valid <= 1'b1;
               req_priority_req <= next_word.key;
               req_payload <= next_word.handle;
               req_last_entry <= next_word.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each accepted word against the oldest one due
   always @(posedge clock) begin : watch_rsp
      sorted_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               report_mismatch("word with nothing due, key", '0, rsp_sorted_priority);
            end else begin
               want = due_words.pop_front();
               if (rsp_sorted_priority !== want.key)
                  report_mismatch("sorted_priority", want.key, rsp_sorted_priority);
               if (rsp_sorted_payload !== want.handle)
                  report_mismatch("sorted_payload", want.handle, rsp_sorted_payload);
               if (rsp_end_of_list !== want.end_flag)
                  report_mismatch("end_of_list", want.end_flag, rsp_end_of_list);
               if (rsp_overflowed !== want.drop_flag)
                  report_mismatch("overflowed", want.drop_flag, rsp_overflowed);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic offer(input logic signed [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle,
                        input logic last);
      req_word_type w;
      w.key = key;
      w.handle = handle;
      w.last = last;
      req_words_waiting.push_back(w);
   endtask

   // queue n words of one set; the final one carries last only when closes is set
   task automatic queue_set(input int n, input bit closes);
      key_flavor_type flavor;
      logic signed [KEY_W-1:0] key;
      flavor = key_flavor_type'($urandom_range(2));
      for (int i = 0; i < n; i++) begin
         case (flavor)
            KEYS_FEW_VALUES: key = $signed($urandom_range(4)) - 2;
            KEYS_EXTREMES: begin
               case ($urandom_range(4))
                  0: key = KEY_MIN;
                  1: key = KEY_MAX;
                  2: key = 0;
                  3: key = -1;
                  default: key = 1;
               endcase
            end
            default: key = $urandom;
         endcase
         offer(key, $urandom, closes && (i == n - 1));
      end
   endtask

   // wait until every word is accepted and delivered, then let insertion finish
   task automatic wait_quiet();
      while (req_words_waiting.size() != 0 || req_valid) @(negedge clock);
      while (due_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // single csr write; only called while the block is idle
   task automatic write_direction(input sort_order_type order);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_descending <= order;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sort_order = order;
   endtask

   initial begin : stimulus
      int item_total;
      int set_len;
      int split;
      // every input known from time zero
      reset = 1'b1;
      req_valid = 1'b0;
      req_priority_req = '0;
      req_payload = '0;
      req_last_entry = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_descending = 1'b0;
      stored_count = 0;
      entries_dropped = 1'b0;
      sort_order = ORDER_ASCENDING;
      mismatch_count = 0;
      cycle_count = 0;
      send_idle_pct = 23;
      recv_idle_pct = 62;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ascending after reset: lone last word, extremes, then ties
      offer(KEY_MIN, 32'h0000_0000, 1'b1);
      offer(KEY_MAX, 32'hffff_ffff, 1'b0);
      offer(KEY_MIN, 32'h0000_0001, 1'b0);
      offer(0, 32'h0000_0002, 1'b0);
      offer(-1, 32'h0000_0003, 1'b0);
      offer(1, 32'h0000_0004, 1'b1);
      offer(5, 32'h0000_0011, 1'b0);
      offer(4, 32'h0000_0012, 1'b0);
      offer(5, 32'h0000_0013, 1'b0);
      offer(5, 32'h0000_0014, 1'b1);
      wait_quiet();
      write_direction(ORDER_DESCENDING);

      // same extremes and ties, descending
      offer(KEY_MIN, 32'h8000_0000, 1'b0);
      offer(0, 32'h0000_0021, 1'b0);
      offer(KEY_MAX, 32'h7fff_ffff, 1'b0);
      offer(-1, 32'h0000_0022, 1'b0);
      offer(1, 32'h0000_0023, 1'b0);
      offer(KEY_MAX, 32'h0000_0024, 1'b0);
      offer(0, 32'h0000_0025, 1'b0);
      offer(-1, 32'h0000_0026, 1'b1);

      // direction flipped while a set is half collected
      offer(7, 32'h0000_0031, 1'b0);
      offer(KEY_MIN, 32'h0000_0032, 1'b0);
      offer(7, 32'h0000_0033, 1'b0);
      wait_quiet();
      write_direction(ORDER_ASCENDING);
      offer(7, 32'h0000_0034, 1'b0);
      offer(-7, 32'h0000_0035, 1'b1);

      // random sets in three idle phases
      item_total = 0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // one set past capacity: fills the store, drops the tail including last
         if (phase == 1) begin
            set_len = MAX_ENTRIES + $urandom_range(1, 3);
            queue_set(set_len, 1'b1);
            item_total += set_len;
         end
         while (item_total < (phase + 1) * RANDOM_ITEMS / 3) begin
            if ($urandom_range(3) == 0) begin
               wait_quiet();
               write_direction(sort_order_type'($urandom_range(1)));
            end
            set_len = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 32);
            if (set_len > 1 && $urandom_range(9) == 0) begin
               // mid-set direction change
               split = $urandom_range(1, set_len - 1);
               queue_set(split, 1'b0);
               wait_quiet();
               write_direction(sort_order_type'(~sort_order));
               queue_set(set_len - split, 1'b1);
            end else begin
               queue_set(set_len, 1'b1);
            end
            item_total += set_len;
         end
      end

      wait_quiet();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
